[hdl/tqla_pkg.sv]
// shared types, codes and constants of the tabular q-learning agent
`default_nettype none

package tqla_pkg;

  localparam int Q_W      = 32;
  localparam int RATE_W   = 16;
  localparam int CFG_IDX_W = 3;

  // input item kinds, carried on in_tuser
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_CHOOSE = 2'd1,
    KIND_UPDATE = 2'd2,
    KIND_DECAY  = 2'd3
  } kind_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd4;

  // reset values, unsigned q0.16
  localparam logic [RATE_W-1:0] LEARN_RST    = 16'd6554;
  localparam logic [RATE_W-1:0] DISCOUNT_RST = 16'd58982;
  localparam logic [RATE_W-1:0] START_RST    = 16'd58982;
  localparam logic [RATE_W-1:0] FLOOR_RST    = 16'd3277;
  localparam logic [RATE_W-1:0] DECAY_RST    = 16'd65503;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_OLD,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL_G,
    ST_DIFF,
    ST_MUL_A,
    ST_WRITE,
    ST_DECAY,
    ST_DONE
  } fsm_t;

endpackage

`default_nettype wire

[hdl/tabular_q_learning_agent.sv]
// Tabular Q-learning agent: epsilon-greedy choice and Q-value update on a table in RAM
//
// Input stream (in_*): one transaction per item; in_tuser holds the item kind
// (load, choose, update, decay), in_tdata the operands. Output stream (out_*):
// exactly one result transaction per item, in order. Config channel (cfg_*):
// register writes, taken only while no item is in flight.
// Items are processed one at a time. The row scan reads one entry per cycle
// through the single RAM port; an update adds the gamma multiply, the
// difference and the alpha multiply, each registered.
// Table entries start undefined; they must be loaded before being read.
// Reset (rst_n low, synchronous) restores the register defaults and the
// exploration rate and empties the output register. The result sits in an
// output register, so the next item is accepted while it waits; when the
// receiver stalls, a finished item holds in its last state until the slot
// frees, and no further item is accepted.
`default_nettype none

module tabular_q_learning_agent #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // in_tdata from bit 0: state_index[8], action_index[2], reward[32],
  // next_state_index[8], load_value[32], explore_draw[16], random_action[2], pad[4]
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [103:0]                       in_tdata,
  // in_tuser: kind[2]
  input  wire logic [1:0]                         in_tuser,
  // out_tdata from bit 0: chosen_action[2], explored[1], q_value[32],
  // exploration_rate[16], pad[5]
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [55:0]                             out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tqla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tqla_pkg::RATE_W-1:0]        cfg_data
);
  import tqla_pkg::*;

  localparam int ROW_W = $clog2(NUM_STATES);
  localparam int COL_W = $clog2(NUM_ACTIONS);
  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW    = $clog2(DEPTH);

  // index reduction tables, built at elaboration
  logic [ROW_W-1:0] row_lut [256];
  logic [COL_W-1:0] col_lut [4];

  for (genvar i = 0; i < 256; i++) begin : g_row_lut
    localparam int RV = i % NUM_STATES;
    assign row_lut[i] = ROW_W'(RV);
  end
  for (genvar j = 0; j < 4; j++) begin : g_col_lut
    localparam int CV = j % NUM_ACTIONS;
    assign col_lut[j] = COL_W'(CV);
  end

  // configuration
  logic [RATE_W-1:0] learn_r, discount_r, floor_r, decay_r, expl_r;
  logic              cfg_fire;

  // item fields
  kind_t                 kind_r;
  logic [ROW_W-1:0]      row_r, next_row_r;
  logic [COL_W-1:0]      col_r, rnd_r;
  logic signed [Q_W-1:0] reward_r, load_r, old_r;
  logic [RATE_W-1:0]     draw_r;

  fsm_t state_r, state_nxt;
  logic [COL_W-1:0] scan_cnt_r;
  logic             scan_last;

  // read tags, aligned with the registered ram data
  logic             rd_old_r, rd_scan_r;
  logic [COL_W-1:0] rd_col_r;

  // fsm outputs
  logic ram_re, ram_we, issue_old, issue_scan;

  logic [ROW_W-1:0]      row_sel;
  logic [COL_W-1:0]      col_sel;
  logic [AW-1:0]         ram_addr;
  logic [Q_W-1:0]        ram_rdata;
  logic signed [Q_W-1:0] wr_value;

  logic signed [Q_W-1:0] best_val;
  logic [COL_W-1:0]      best_col;

  // update arithmetic
  logic signed [48:0] prod_g_r;
  logic signed [34:0] diff_r;
  logic signed [51:0] prod_a_r;
  logic signed [32:0] g_term;
  logic signed [35:0] delta;
  logic signed [36:0] sum_w;
  logic signed [Q_W-1:0] sat_value;

  // decay arithmetic
  logic [31:0]       decay_prod;
  logic [RATE_W-1:0] decay_rate;

  // result
  logic                  res_expl_r;
  logic signed [Q_W-1:0] res_q_r;
  logic                  out_valid_r;
  logic [55:0]           out_data_r;
  logic                  out_load;
  logic [1:0]            out_chosen;
  logic [Q_W-1:0]        out_q;

  logic in_fire;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign scan_last = (scan_cnt_r == COL_W'(NUM_ACTIONS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (kind_r)
          KIND_LOAD:   state_nxt = ST_WRITE;
          KIND_CHOOSE: state_nxt = (draw_r < expl_r) ? ST_DONE : ST_SCAN;
          KIND_UPDATE: state_nxt = ST_OLD;
          KIND_DECAY:  state_nxt = ST_DECAY;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_OLD:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = (kind_r == KIND_UPDATE) ? ST_MUL_G : ST_DONE;
      ST_MUL_G: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL_A;
      ST_MUL_A: state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DECAY: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    issue_old  = 1'b0;
    issue_scan = 1'b0;
    case (state_r)
      ST_OLD: begin
        ram_re    = 1'b1;
        issue_old = 1'b1;
      end
      ST_SCAN: begin
        ram_re     = 1'b1;
        issue_scan = 1'b1;
      end
      ST_WRITE: ram_we = 1'b1;
      default: ;
    endcase
  end

  // one address path for old entry, row scan and write-back
  always_comb begin
    row_sel = (issue_scan && (kind_r == KIND_UPDATE)) ? next_row_r : row_r;
    col_sel = issue_scan ? scan_cnt_r : col_r;
  end
  assign ram_addr = AW'(row_sel) * AW'(NUM_ACTIONS) + AW'(col_sel);

  // floor shifts are plain arithmetic right shifts of the products
  assign g_term = $signed(prod_g_r[48:16]);
  assign delta  = $signed(prod_a_r[51:16]);
  assign sum_w  = 37'(old_r) + 37'(delta);

  always_comb begin
    if (sum_w > 37'sd2147483647) begin
      sat_value = 32'sh7fffffff;
    end else if (sum_w < -37'sd2147483648) begin
      sat_value = 32'sh80000000;
    end else begin
      sat_value = sum_w[31:0];
    end
  end

  assign wr_value = (kind_r == KIND_LOAD) ? load_r : sat_value;

  assign decay_prod = 32'(expl_r) * 32'(decay_r);
  assign decay_rate = (decay_prod[31:16] < floor_r) ? floor_r : decay_prod[31:16];

  tqla_value_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .re    (ram_re),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_value),
    .rdata (ram_rdata)
  );

  tqla_row_max #(
    .COL_W (COL_W)
  ) u_row_max (
    .clk      (clk),
    .el_valid (rd_scan_r),
    .el_col   (rd_col_r),
    .el_data  ($signed(ram_rdata)),
    .best_val (best_val),
    .best_col (best_col)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      rd_old_r    <= 1'b0;
      rd_scan_r   <= 1'b0;
      out_valid_r <= 1'b0;
      learn_r     <= LEARN_RST;
      discount_r  <= DISCOUNT_RST;
      floor_r     <= FLOOR_RST;
      decay_r     <= DECAY_RST;
      expl_r      <= START_RST;
    end else begin
      state_r   <= state_nxt;
      rd_old_r  <= issue_old;
      rd_scan_r <= issue_scan;
      if (issue_scan) begin
        scan_cnt_r <= scan_last ? '0 : scan_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_index)
          REG_LEARN:    learn_r    <= cfg_data;
          REG_DISCOUNT: discount_r <= cfg_data;
          REG_START:    expl_r     <= cfg_data;
          REG_FLOOR:    floor_r    <= cfg_data;
          REG_DECAY:    decay_r    <= cfg_data;
          default: ;
        endcase
      end else if (state_r == ST_DECAY) begin
        expl_r <= decay_rate;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_col_r <= scan_cnt_r;
    if (in_fire) begin
      kind_r     <= kind_t'(in_tuser);
      row_r      <= row_lut[in_tdata[7:0]];
      col_r      <= col_lut[in_tdata[9:8]];
      reward_r   <= $signed(in_tdata[41:10]);
      next_row_r <= row_lut[in_tdata[49:42]];
      load_r     <= $signed(in_tdata[81:50]);
      draw_r     <= in_tdata[97:82];
      rnd_r      <= col_lut[in_tdata[99:98]];
    end
    if (state_r == ST_DISPATCH) begin
      res_expl_r <= (kind_r == KIND_CHOOSE) && (draw_r < expl_r);
    end
    if (rd_old_r) old_r <= $signed(ram_rdata);
    if (state_r == ST_MUL_G) prod_g_r <= best_val * $signed({1'b0, discount_r});
    if (state_r == ST_DIFF)  diff_r   <= 35'(reward_r) + 35'(g_term) - 35'(old_r);
    if (state_r == ST_MUL_A) prod_a_r <= diff_r * $signed({1'b0, learn_r});
    if (state_r == ST_WRITE) res_q_r  <= wr_value;
    if (out_load) out_data_r <= {5'd0, expl_r, out_q, res_expl_r, out_chosen};
  end

  always_comb begin
    out_chosen = 2'd0;
    if (kind_r == KIND_CHOOSE) begin
      out_chosen = res_expl_r ? 2'(rnd_r) : 2'(best_col);
    end
    out_q = ((kind_r == KIND_LOAD) || (kind_r == KIND_UPDATE)) ? res_q_r : '0;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the table is only written in the write-back step, never while a read is in flight
  a_write_alone: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!rd_old_r && !rd_scan_r))
    else $error("table write overlaps a pending read");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_DISPATCH))
    else $error("accepted item not dispatched");

  a_decay_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECAY) |=> (expl_r >= floor_r))
    else $error("exploration rate below floor after decay");

  a_explore_no_q: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[2]) |-> (out_data_r[34:3] == '0))
    else $error("explored result carries a q value");

endmodule

`default_nettype wire

[hdl/tqla_value_ram.sv]
// single-port value table memory with registered read data
`default_nettype none

module tqla_value_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic                      clk,
  input  wire logic                      re,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [tqla_pkg::Q_W-1:0]  wdata,
  output logic      [tqla_pkg::Q_W-1:0]  rdata
);
  import tqla_pkg::*;

  logic [Q_W-1:0] mem [DEPTH];
  logic [Q_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hdl/tqla_row_max.sv]
// running maximum and argmax over one table row, one entry per cycle
`default_nettype none

module tqla_row_max #(
  parameter int COL_W = 2
) (
  input  wire logic                            clk,
  input  wire logic                            el_valid,
  input  wire logic [COL_W-1:0]                el_col,
  input  wire logic signed [tqla_pkg::Q_W-1:0] el_data,
  output logic signed [tqla_pkg::Q_W-1:0]      best_val,
  output logic      [COL_W-1:0]                best_col
);
  import tqla_pkg::*;

  logic signed [Q_W-1:0] best_val_r;
  logic [COL_W-1:0]      best_col_r;

  // first column seeds the search, later ones win only when strictly larger
  always_ff @(posedge clk) begin
    if (el_valid && ((el_col == '0) || (el_data > best_val_r))) begin
      best_val_r <= el_data;
      best_col_r <= el_col;
    end
  end

  assign best_val = best_val_r;
  assign best_col = best_col_r;

endmodule

`default_nettype wire
